@@ design/hrhs_pkg.sv @@
// Shared constants, types and lookup functions for the HTTP request header scanner.
`default_nettype none

package hrhs_pkg;

    localparam int MAX_SCAN_DEF     = 2048;
    localparam int METHOD_COUNT_DEF = 8;
    localparam int METHOD_SLOTS     = 8;

    localparam int URI_W  = 11;
    localparam int HOST_W = 12;
    localparam int CODE_W = 3;

    // output word: method_code, line_found, uri_start, uri_length,
    // host_found, host_start, host_length (51 bits, padded to 56)
    localparam int OUT_TDATA_W = 56;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] HOST_KEY_LEN = 3'd7;

    // one byte step, as seen by the tracking units
    typedef struct packed {
        logic [7:0] data;
        logic       take;     // byte falls inside the scan window
        logic       done;     // last byte of the payload is being processed
        logic       prev_cr;  // previous scanned byte was CR
    } step_t;

    function automatic logic [3:0] method_len(input logic [2:0] slot);
        logic [3:0] len;
        case (slot)
            3'd0:    len = 4'd4;
            3'd1:    len = 4'd5;
            3'd2:    len = 4'd4;
            3'd3:    len = 4'd7;
            3'd4:    len = 4'd5;
            3'd5:    len = 4'd8;
            3'd6:    len = 4'd6;
            default: len = 4'd8;
        endcase
        return len;
    endfunction

    // method words with their trailing space; GET POST PUT DELETE HEAD
    // OPTIONS PATCH CONNECT
    function automatic logic [7:0] method_char(input logic [2:0] slot,
                                               input logic [2:0] idx);
        logic [63:0] word;
        case (slot)
            3'd0:    word = {8'h00, 8'h00, 8'h00, 8'h00, " ", "T", "E", "G"};
            3'd1:    word = {8'h00, 8'h00, 8'h00, " ", "T", "S", "O", "P"};
            3'd2:    word = {8'h00, 8'h00, 8'h00, 8'h00, " ", "T", "U", "P"};
            3'd3:    word = {8'h00, " ", "E", "T", "E", "L", "E", "D"};
            3'd4:    word = {8'h00, 8'h00, 8'h00, " ", "D", "A", "E", "H"};
            3'd5:    word = {" ", "S", "N", "O", "I", "T", "P", "O"};
            3'd6:    word = {8'h00, 8'h00, " ", "H", "C", "T", "A", "P"};
            default: word = {" ", "T", "C", "E", "N", "N", "O", "C"};
        endcase
        return word[{idx, 3'b000} +: 8];
    endfunction

    // CR LF "host:"
    function automatic logic [7:0] host_key_char(input logic [2:0] k);
        logic [7:0] c;
        case (k)
            3'd0:    c = CHAR_CR;
            3'd1:    c = CHAR_LF;
            3'd2:    c = "h";
            3'd3:    c = "o";
            3'd4:    c = "s";
            3'd5:    c = "t";
            3'd6:    c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= "A" && c <= "Z")
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/hrhs_method.sv @@
// Method word matcher: per-slot alive bits and first-match code select.
`default_nettype none

module hrhs_method #(
    parameter int METHOD_COUNT = hrhs_pkg::METHOD_COUNT_DEF,
    parameter int POS_W        = 12
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire hrhs_pkg::step_t         step,
    input  wire  [POS_W-1:0]             pos,
    input  wire  [POS_W-1:0]             scan_len,
    output logic                         is_http,
    output logic [hrhs_pkg::CODE_W-1:0]  method_code
);

    localparam int EXT_W = (POS_W > 4) ? POS_W : 4;

    logic [METHOD_COUNT-1:0] alive_reg;
    logic [METHOD_COUNT-1:0] alive_next;
    logic [METHOD_COUNT-1:0] alive_upd;

    always_comb
    begin
        for (int i = 0; i < METHOD_COUNT; i++)
        begin
            alive_upd[i] = alive_reg[i];
            if (step.take && (EXT_W'(pos) < EXT_W'(hrhs_pkg::method_len(3'(i))))
                && (hrhs_pkg::method_char(3'(i), pos[2:0]) != step.data))
            begin
                alive_upd[i] = 1'b0;
            end
        end
    end

    // first surviving word that fits in the scanned length wins
    always_comb
    begin
        is_http     = 1'b0;
        method_code = '0;
        for (int i = METHOD_COUNT - 1; i >= 0; i--)
        begin
            if (alive_upd[i]
                && (EXT_W'(hrhs_pkg::method_len(3'(i))) <= EXT_W'(scan_len)))
            begin
                is_http     = 1'b1;
                method_code = hrhs_pkg::CODE_W'(i);
            end
        end
    end

    assign alive_next = step.done ? '1 : alive_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '1;
        end
        else
        begin
            alive_reg <= alive_next;
        end
    end

endmodule

`default_nettype wire

@@ design/hrhs_line.sv @@
// Request line tracker: first CRLF and the two spaces that bound the URI.
`default_nettype none

module hrhs_line #(
    parameter int POS_W = 12
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire hrhs_pkg::step_t        step,
    input  wire  [POS_W-1:0]            pos,
    output logic                        line_found,
    output logic [hrhs_pkg::URI_W-1:0]  uri_start,
    output logic [hrhs_pkg::URI_W-1:0]  uri_length
);

    localparam int EXT_W = (POS_W > hrhs_pkg::HOST_W) ? POS_W : hrhs_pkg::HOST_W;

    logic             line_end_reg, line_end_next, line_end_upd;
    logic             fs_seen_reg, fs_seen_next, fs_seen_upd;
    logic             ss_seen_reg, ss_seen_next, ss_seen_upd;
    logic [POS_W-1:0] fs_at_reg, fs_at_next, fs_at_upd;
    logic [POS_W-1:0] ss_at_reg, ss_at_next, ss_at_upd;
    logic [EXT_W-1:0] start_ext;
    logic [EXT_W-1:0] len_ext;

    always_comb
    begin
        line_end_upd = line_end_reg;
        fs_seen_upd  = fs_seen_reg;
        ss_seen_upd  = ss_seen_reg;
        fs_at_upd    = fs_at_reg;
        ss_at_upd    = ss_at_reg;
        if (step.take && !line_end_reg)
        begin
            if (step.data == hrhs_pkg::CHAR_LF && step.prev_cr)
            begin
                line_end_upd = 1'b1;
            end
            else if (step.data == hrhs_pkg::CHAR_SPACE)
            begin
                if (!fs_seen_reg)
                begin
                    fs_at_upd   = pos;
                    fs_seen_upd = 1'b1;
                end
                else if (!ss_seen_reg)
                begin
                    ss_at_upd   = pos;
                    ss_seen_upd = 1'b1;
                end
            end
        end
    end

    assign start_ext  = EXT_W'(fs_at_upd) + EXT_W'(1);
    assign len_ext    = EXT_W'(ss_at_upd) - EXT_W'(fs_at_upd) - EXT_W'(1);
    assign line_found = line_end_upd && ss_seen_upd;
    assign uri_start  = start_ext[hrhs_pkg::URI_W-1:0];
    assign uri_length = len_ext[hrhs_pkg::URI_W-1:0];

    assign line_end_next = line_end_upd && !step.done;
    assign fs_seen_next  = fs_seen_upd && !step.done;
    assign ss_seen_next  = ss_seen_upd && !step.done;
    assign fs_at_next    = step.done ? '0 : fs_at_upd;
    assign ss_at_next    = step.done ? '0 : ss_at_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_end_reg <= 1'b0;
            fs_seen_reg  <= 1'b0;
            ss_seen_reg  <= 1'b0;
            fs_at_reg    <= '0;
            ss_at_reg    <= '0;
        end
        else
        begin
            line_end_reg <= line_end_next;
            fs_seen_reg  <= fs_seen_next;
            ss_seen_reg  <= ss_seen_next;
            fs_at_reg    <= fs_at_next;
            ss_at_reg    <= ss_at_next;
        end
    end

endmodule

`default_nettype wire

@@ design/hrhs_host.sv @@
// Host header tracker: CRLF "host:" key search, space skip and value bounds.
`default_nettype none

module hrhs_host #(
    parameter int POS_W = 12
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire hrhs_pkg::step_t         step,
    input  wire  [POS_W-1:0]             pos,
    input  wire  [POS_W-1:0]             scan_len,
    output logic                         host_found,
    output logic [hrhs_pkg::HOST_W-1:0]  host_start,
    output logic [hrhs_pkg::HOST_W-1:0]  host_length
);

    localparam int EXT_W = (POS_W > hrhs_pkg::HOST_W) ? POS_W : hrhs_pkg::HOST_W;

    logic [2:0]       kp_reg, kp_next, kp_upd;
    logic             found_reg, found_next, found_upd;
    logic             skip_reg, skip_next, skip_upd;
    logic             vend_seen_reg, vend_seen_next, vend_seen_upd;
    logic [POS_W-1:0] vstart_reg, vstart_next, vstart_upd;
    logic [POS_W-1:0] vend_reg, vend_next, vend_upd;
    logic [7:0]       lc;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic [EXT_W-1:0] len_ext;

    assign lc = hrhs_pkg::lower_ascii(step.data);

    always_comb
    begin
        kp_upd        = kp_reg;
        found_upd     = found_reg;
        skip_upd      = skip_reg;
        vend_seen_upd = vend_seen_reg;
        vstart_upd    = vstart_reg;
        vend_upd      = vend_reg;
        if (step.take)
        begin
            if (found_reg)
            begin
                if (skip_reg)
                begin
                    if (step.data != hrhs_pkg::CHAR_SPACE)
                    begin
                        vstart_upd = pos;
                        skip_upd   = 1'b0;
                    end
                end
                else if (!vend_seen_reg && step.data == hrhs_pkg::CHAR_LF
                         && step.prev_cr && pos > vstart_reg)
                begin
                    vend_upd      = pos - POS_W'(1);
                    vend_seen_upd = 1'b1;
                end
            end
            else
            begin
                // a mismatch on CR restarts the key at its second character
                if (kp_reg < hrhs_pkg::HOST_KEY_LEN && lc == hrhs_pkg::host_key_char(kp_reg))
                begin
                    kp_upd = kp_reg + 3'd1;
                end
                else
                begin
                    kp_upd = (lc == hrhs_pkg::CHAR_CR) ? 3'd1 : 3'd0;
                end
                if (kp_upd == hrhs_pkg::HOST_KEY_LEN)
                begin
                    found_upd = 1'b1;
                    skip_upd  = 1'b1;
                end
            end
        end
    end

    assign start_pos   = skip_upd ? scan_len : vstart_upd;
    assign end_pos     = vend_seen_upd ? vend_upd : scan_len;
    assign len_ext     = EXT_W'(end_pos) - EXT_W'(start_pos);
    assign host_found  = found_upd;
    assign host_start  = hrhs_pkg::HOST_W'(EXT_W'(start_pos));
    assign host_length = len_ext[hrhs_pkg::HOST_W-1:0];

    assign kp_next        = step.done ? 3'd0 : kp_upd;
    assign found_next     = found_upd && !step.done;
    assign skip_next      = skip_upd && !step.done;
    assign vend_seen_next = vend_seen_upd && !step.done;
    assign vstart_next    = step.done ? '0 : vstart_upd;
    assign vend_next      = step.done ? '0 : vend_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= 3'd0;
            found_reg     <= 1'b0;
            skip_reg      <= 1'b0;
            vend_seen_reg <= 1'b0;
            vstart_reg    <= '0;
            vend_reg      <= '0;
        end
        else
        begin
            kp_reg        <= kp_next;
            found_reg     <= found_next;
            skip_reg      <= skip_next;
            vend_seen_reg <= vend_seen_next;
            vstart_reg    <= vstart_next;
            vend_reg      <= vend_next;
        end
    end

endmodule

`default_nettype wire

@@ design/http_request_header_scanner_unit.sv @@
// Top level of the HTTP request header scanner: byte register, position, result register.
//
//  channel | dir | tdata                   | tuser   | tlast
//  s_axis  | in  | data_byte[7:0]          | -       | last_byte
//  m_axis  | out | see port comment (51 b) | is_http | -
//
// One byte word per cycle, sustained while no tlast word is stalled; a result is
// valid once the word carrying tlast has passed through the input register and
// been caught by the result register.
// The per-byte update is one pass of compares and a position increment.
// Reset clears the scan state, the position and both valid flags.
// A full result register stalls only a tlast word; other words keep flowing.
// After each result all scan state returns to its reset values.
`default_nettype none

module http_request_header_scanner_unit #(
    parameter int MAX_SCAN     = hrhs_pkg::MAX_SCAN_DEF,
    parameter int METHOD_COUNT = hrhs_pkg::METHOD_COUNT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [7:0]                         s_axis_tdata,  // data_byte[7:0]
    input  wire                                s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [2:0] method_code, [3] line_found, [14:4] uri_start, [25:15] uri_length,
    // [26] host_found, [38:27] host_start, [50:39] host_length, [55:51] zero
    output logic [hrhs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tuser   // is_http
);

    localparam int POS_W = $clog2(MAX_SCAN + 1);

    logic                             in_valid_reg, in_valid_next;
    logic [7:0]                       in_data_reg;
    logic                             in_last_reg;
    logic [POS_W-1:0]                 pos_reg, pos_next;
    logic                             prev_cr_reg, prev_cr_next;
    logic                             out_valid_reg, out_valid_next;
    logic [hrhs_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                             out_http_reg;

    logic                             proc;
    logic                             take;
    logic [POS_W-1:0]                 scan_len;
    hrhs_pkg::step_t                  step;

    logic                             is_http;
    logic [hrhs_pkg::CODE_W-1:0]      method_code;
    logic                             line_found;
    logic [hrhs_pkg::URI_W-1:0]       uri_start, uri_length;
    logic                             host_found;
    logic [hrhs_pkg::HOST_W-1:0]      host_start, host_length;
    logic [hrhs_pkg::OUT_TDATA_W-1:0] result;

    // a non-last word never waits on the output side
    assign proc          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign take          = proc && (pos_reg < POS_W'(MAX_SCAN));
    assign scan_len      = pos_reg + POS_W'(take);

    assign step.data    = in_data_reg;
    assign step.take    = take;
    assign step.done    = proc && in_last_reg;
    assign step.prev_cr = prev_cr_reg;

    hrhs_method #(
        .METHOD_COUNT (METHOD_COUNT),
        .POS_W        (POS_W)
    ) u_method (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pos         (pos_reg),
        .scan_len    (scan_len),
        .is_http     (is_http),
        .method_code (method_code)
    );

    hrhs_line #(
        .POS_W (POS_W)
    ) u_line (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .pos        (pos_reg),
        .line_found (line_found),
        .uri_start  (uri_start),
        .uri_length (uri_length)
    );

    hrhs_host #(
        .POS_W (POS_W)
    ) u_host (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pos         (pos_reg),
        .scan_len    (scan_len),
        .host_found  (host_found),
        .host_start  (host_start),
        .host_length (host_length)
    );

    always_comb
    begin
        result = '0;
        if (is_http)
        begin
            result[2:0] = method_code;
            if (line_found)
            begin
                result[3]     = 1'b1;
                result[14:4]  = uri_start;
                result[25:15] = uri_length;
            end
            if (host_found)
            begin
                result[26]    = 1'b1;
                result[38:27] = host_start;
                result[50:39] = host_length;
            end
        end
    end

    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign pos_next       = !proc ? pos_reg : (step.done ? '0 : scan_len);
    assign prev_cr_next   = step.done ? 1'b0
                          : (take ? (in_data_reg == hrhs_pkg::CHAR_CR) : prev_cr_reg);
    assign out_valid_next = step.done || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            prev_cr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            pos_reg       <= pos_next;
            prev_cr_reg   <= prev_cr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (step.done)
        begin
            out_data_reg <= result;
            out_http_reg <= is_http;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_http_reg;

endmodule

`default_nettype wire

@@ design/hrhs_checker.sv @@
// Port-level checks for the HTTP request header scanner, bound to the top level.
`default_nettype none

module hrhs_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [hrhs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input wire                                m_axis_tuser
);

    // a held result keeps its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // non-HTTP payloads report all-zero fields
    a_not_http_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("non-HTTP result carries nonzero fields");

    a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[25:4] == '0)
        else $error("URI fields set without request line");

    a_no_host_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[26] |-> m_axis_tdata[50:39] == '0
            && m_axis_tdata[38:27] == '0)
        else $error("host fields set without host key");

    // input side is free whenever nothing is buffered and no result is pending
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && $past(!s_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled with empty datapath");

endmodule

bind http_request_header_scanner_unit hrhs_checker u_hrhs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
